FILE: rtl/psvg_pkg.sv
// Shared types, constants and helpers of the polar sphere vertex generator.
`default_nettype none

package psvg_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SECTORS  = 2'd0,
    CFG_NUM_RINGS    = 2'd1,
    CFG_RADIUS_SCALE = 2'd2
  } cfg_idx_e;

  // Upper bounds applied to the count registers.
  localparam logic [10:0] MAX_SECTORS = 11'd1024;
  localparam logic [10:0] MAX_RINGS   = 11'd1024;

  // Rotation CORDIC in Q2.30, angles in units of 2^-20 turn.
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [19:0] ATAN_TURN20 [CORDIC_STEPS] = '{
    20'sd131072, 20'sd77376, 20'sd40883, 20'sd20753,
    20'sd10417,  20'sd5213,  20'sd2607,  20'sd1304,
    20'sd652,    20'sd326,   20'sd163,   20'sd81,
    20'sd41,     20'sd20,    20'sd10,    20'sd5
  };

  // Bit-by-bit square root of a 60-bit operand.
  localparam int SQRT_W     = 60;
  localparam int SQRT_STEPS = 30;

  // Cosine and sine of the sector angle, Q.20.
  typedef struct packed {
    logic signed [21:0] c20;
    logic signed [21:0] s20;
  } cs_pair_t;

  // Clamp a signed value to the 16-bit coordinate range.
  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'h7fff;
    end else if (v < -32'sd32768) begin
      return 16'h8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/psvg_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module psvg_div #(
  parameter int DW = 30,
  parameter int VW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic      [DW-1:0] quotient_o
);

  // The divisor is a configuration value and must hold while work is in flight.
  logic [VW-1:0] rem_q [DW];
  logic [DW-1:0] acc_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [DW-1:0] acc_in;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign acc_in = dividend_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    assign trial = {rem_in, acc_in[DW-1]};
    assign diff  = trial - {1'b0, divisor_i};
    assign ge    = (trial >= {1'b0, divisor_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
        acc_q[k] <= {acc_in[DW-2:0], ge};
      end
    end
  end

  assign quotient_o = acc_q[DW-1];

endmodule

`default_nettype wire

FILE: rtl/polar_sphere_vertex_gen_unit.sv
// Top level of the polar sphere vertex generator: one vertex per transaction.
//
// Usage: each slave-side transaction names one vertex by sector and ring. The
// block answers with one master-side transaction holding the vertex number,
// the scaled position (signed Q8.8, saturated) and the texture coordinates.
// Configuration (sector count, ring count, size factor) is written through the
// plain write port while no transaction is in flight.
// The ring radius path sets the pipeline depth: a 30-stage square root
// followed by a 30-stage divider, two multiplier stages and a rounding stage.
// Throughput is one transaction per cycle while the output is not stalled;
// every stage is a register slice and valid bits travel with the data.
// Reset clears the valid bits and loads the register defaults (16 sectors,
// 16 rings, size 1.0). The whole pipeline holds and s_axis_tready drops
// only while the final stage holds a result that the receiver does not take.
`default_nettype none

module polar_sphere_vertex_gen_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [psvg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]                    cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: sector_idx[9:0], ring_idx[9:0], zero fill.
  input  wire logic [23:0]                    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // Fields from bit 0 up: vertex_number[19:0], pos_x[15:0], pos_y[15:0],
  // pos_z[15:0], tex_u[15:0], tex_v[15:0], zero fill.
  output logic [103:0]                        m_axis_tdata
);

  import psvg_pkg::*;

  localparam int LAST_STAGE = 64;

  // Configuration registers.
  logic [10:0]        ns_q, nr_q;
  logic signed [15:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q  <= 11'd16;
      nr_q  <= 11'd16;
      rad_q <= 16'sd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_SECTORS:  ns_q  <= cfg_wdata_i[10:0];
        CFG_NUM_RINGS:    nr_q  <= cfg_wdata_i[10:0];
        CFG_RADIUS_SCALE: rad_q <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Effective counts. A zero sector count acts as one sector; fewer than two
  // rings collapse every vertex onto the bottom pole.
  logic [10:0] ns_eff, nr_c, nrv;
  logic [9:0]  d_val;
  logic        d_zero;

  always_comb begin
    ns_eff = (ns_q == 11'd0) ? 11'd1 : ((ns_q > MAX_SECTORS) ? MAX_SECTORS : ns_q);
    nr_c   = (nr_q > MAX_RINGS) ? MAX_RINGS : nr_q;
    nrv    = (nr_c == 11'd0) ? 11'd1 : nr_c;
    d_zero = (nr_c < 11'd2);
    d_val  = d_zero ? 10'd0 : 10'(nr_c - 11'd1);
  end

  // Pipeline control: every stage advances unless the final result is stuck.
  logic                pipe_en;
  logic [LAST_STAGE:0] vld_q;

  assign pipe_en       = !vld_q[LAST_STAGE] || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = vld_q[LAST_STAGE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAST_STAGE-1:0], s_axis_tvalid};
    end
  end

  // Stage 0: input register.
  logic [9:0] sec0_q, ring0_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sec0_q  <= s_axis_tdata[9:0];
      ring0_q <= s_axis_tdata[19:10];
    end
  end

  // Stage 1: ring radius operand and height numerator.
  logic [19:0]        p_full;
  logic signed [11:0] n12;
  logic [10:0]        an;
  logic [30:0]        ynum;
  logic [17:0]        p1_q;
  logic [30:0]        ynum1_q;
  logic               yneg1_q;

  always_comb begin
    p_full = (!d_zero && (ring0_q <= d_val)) ?
             ({10'd0, ring0_q} * {10'd0, 10'(d_val - ring0_q)}) : 20'd0;
    n12    = signed'({1'b0, ring0_q, 1'b0}) - signed'({2'b00, d_val});
    an     = n12[11] ? 11'(-n12) : n12[10:0];
    ynum   = {an, 20'd0} + {21'd0, d_val >> 1};
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p1_q    <= p_full[17:0];
      ynum1_q <= ynum;
      yneg1_q <= n12[11];
    end
  end

  // Vertex number, carried to the output stage.
  logic [21:0] vn_full;
  logic [19:0] vn_dl_q [LAST_STAGE];

  assign vn_full = {12'd0, ring0_q} * {11'd0, ns_eff} + {12'd0, sec0_q};

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      vn_dl_q[0] <= vn_full[19:0];
      for (int k = 1; k < LAST_STAGE; k++) vn_dl_q[k] <= vn_dl_q[k-1];
    end
  end

  // Texture v: ring * 2^16 / rings, ready at stage 26.
  logic [25:0] quot_v;
  logic [15:0] tex_v;
  logic [15:0] v_dl_q [38];

  psvg_div #(.DW(26), .VW(11)) u_div_v (
    .clk_i      (clk_i),
    .en_i       (pipe_en),
    .dividend_i ({ring0_q, 16'd0}),
    .divisor_i  (nrv),
    .quotient_o (quot_v)
  );

  assign tex_v = (quot_v[25:16] != 10'd0) ? 16'hffff : quot_v[15:0];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      v_dl_q[0] <= tex_v;
      for (int k = 1; k < 38; k++) v_dl_q[k] <= v_dl_q[k-1];
    end
  end

  // Sector phase: sector * 2^20 / sectors, ready at stage 30. Its low 20 bits
  // are the angle in 2^-20 turn; texture u follows from the same quotient.
  logic [29:0] quot_a;
  logic [15:0] tex_u;
  logic [15:0] u_dl_q [34];
  logic [1:0]  quad_dl_q [CORDIC_STEPS];

  psvg_div #(.DW(30), .VW(11)) u_div_a (
    .clk_i      (clk_i),
    .en_i       (pipe_en),
    .dividend_i ({sec0_q, 20'd0}),
    .divisor_i  (ns_eff),
    .quotient_o (quot_a)
  );

  assign tex_u = (quot_a[29:20] != 10'd0) ? 16'hffff : quot_a[19:4];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      u_dl_q[0]    <= tex_u;
      quad_dl_q[0] <= quot_a[19:18];
      for (int k = 1; k < 34; k++) u_dl_q[k] <= u_dl_q[k-1];
      for (int k = 1; k < CORDIC_STEPS; k++) quad_dl_q[k] <= quad_dl_q[k-1];
    end
  end

  // CORDIC rotation over the in-quadrant angle, stages 31 to 46.
  logic signed [32:0] cx_q [CORDIC_STEPS];
  logic signed [32:0] cy_q [CORDIC_STEPS];
  logic signed [19:0] cz_q [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [32:0] x_in, y_in, x_nx, y_nx;
    logic signed [19:0] z_in, z_nx;

    if (k == 0) begin : g_first
      assign x_in = CORDIC_GAIN_Q30;
      assign y_in = '0;
      assign z_in = signed'({2'b00, quot_a[17:0]});
    end else begin : g_next
      assign x_in = cx_q[k-1];
      assign y_in = cy_q[k-1];
      assign z_in = cz_q[k-1];
    end

    always_comb begin
      if (!z_in[19]) begin
        x_nx = x_in - (y_in >>> k);
        y_nx = y_in + (x_in >>> k);
        z_nx = z_in - ATAN_TURN20[k];
      end else begin
        x_nx = x_in + (y_in >>> k);
        y_nx = y_in - (x_in >>> k);
        z_nx = z_in + ATAN_TURN20[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        cx_q[k] <= x_nx;
        cy_q[k] <= y_nx;
        cz_q[k] <= z_nx;
      end
    end
  end

  // Quadrant fold and rounding to Q.20, then delay to meet the ring radius.
  logic signed [32:0] cos_w, sin_w, cos_r, sin_r;
  cs_pair_t           cs_in;
  cs_pair_t           cs_dl_q [15];

  always_comb begin
    case (quad_dl_q[CORDIC_STEPS-1])
      2'd0: begin
        cos_w = cx_q[CORDIC_STEPS-1];
        sin_w = cy_q[CORDIC_STEPS-1];
      end
      2'd1: begin
        cos_w = -cy_q[CORDIC_STEPS-1];
        sin_w = cx_q[CORDIC_STEPS-1];
      end
      2'd2: begin
        cos_w = -cx_q[CORDIC_STEPS-1];
        sin_w = -cy_q[CORDIC_STEPS-1];
      end
      default: begin
        cos_w = cy_q[CORDIC_STEPS-1];
        sin_w = -cx_q[CORDIC_STEPS-1];
      end
    endcase
    cos_r     = cos_w + 33'sd512;
    sin_r     = sin_w + 33'sd512;
    cs_in.c20 = cos_r[31:10];
    cs_in.s20 = sin_r[31:10];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      cs_dl_q[0] <= cs_in;
      for (int k = 1; k < 15; k++) cs_dl_q[k] <= cs_dl_q[k-1];
    end
  end

  // Ring radius: square root over stages 2 to 31, then division by d.
  logic [SQRT_W-1:0] sq_x_q [SQRT_STEPS];
  logic [SQRT_W-1:0] sq_r_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQRT_W-1:0] SQ_BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SQRT_W-1:0] x_in, r_in;
    logic [SQRT_W:0]   sum;
    logic              ge;

    if (k == 0) begin : g_first
      assign x_in = {p1_q, 42'd0};
      assign r_in = '0;
    end else begin : g_next
      assign x_in = sq_x_q[k-1];
      assign r_in = sq_r_q[k-1];
    end

    assign sum = {1'b0, r_in} + {1'b0, SQ_BIT};
    assign ge  = ({1'b0, x_in} >= sum);

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        sq_x_q[k] <= ge ? (x_in - sum[SQRT_W-1:0]) : x_in;
        sq_r_q[k] <= ge ? ((r_in >> 1) + SQ_BIT) : (r_in >> 1);
      end
    end
  end

  logic [29:0] quot_r;

  psvg_div #(.DW(30), .VW(10)) u_div_r (
    .clk_i      (clk_i),
    .en_i       (pipe_en),
    .dividend_i (sq_r_q[SQRT_STEPS-1][29:0]),
    .divisor_i  (d_val),
    .quotient_o (quot_r)
  );

  // Height: rounded (2*ring - d) * 2^20 / d, ready at stage 32.
  logic [30:0]        quot_y;
  logic               yneg_dl_q [31];
  logic signed [31:0] y20;
  logic signed [31:0] y_dl_q [30];

  psvg_div #(.DW(31), .VW(10)) u_div_y (
    .clk_i      (clk_i),
    .en_i       (pipe_en),
    .dividend_i (ynum1_q),
    .divisor_i  (d_val),
    .quotient_o (quot_y)
  );

  always_comb begin
    if (d_zero) begin
      y20 = -32'sd1048576;
    end else if (yneg_dl_q[30]) begin
      y20 = -signed'({1'b0, quot_y});
    end else begin
      y20 = signed'({1'b0, quot_y});
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      yneg_dl_q[0] <= yneg1_q;
      y_dl_q[0]    <= y20;
      for (int k = 1; k < 31; k++) yneg_dl_q[k] <= yneg_dl_q[k-1];
      for (int k = 1; k < 30; k++) y_dl_q[k] <= y_dl_q[k-1];
    end
  end

  // Stage 62: trig times ring radius. Stage 63: times size. Stage 64: round.
  logic signed [21:0] r20s;
  logic signed [43:0] pcx_q, pcz_q;
  logic signed [59:0] pxp_q, pzp_q;
  logic signed [47:0] pyp_q;
  logic signed [59:0] pxr, pzr;
  logic signed [47:0] pyr;
  logic [15:0]        px_q, py_q, pz_q;

  // With fewer than two rings the divisor is zero and the quotient is
  // meaningless, so the ring radius is forced to zero.
  assign r20s = d_zero ? 22'sd0 : signed'({1'b0, quot_r[20:0]});

  always_comb begin
    pxr = pxp_q + (60'sd1 <<< 39);
    pzr = pzp_q + (60'sd1 <<< 39);
    pyr = pyp_q + (48'sd1 <<< 19);
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pcx_q <= cs_dl_q[14].c20 * r20s;
      pcz_q <= cs_dl_q[14].s20 * r20s;
      pxp_q <= pcx_q * rad_q;
      pzp_q <= pcz_q * rad_q;
      pyp_q <= y_dl_q[29] * rad_q;
      px_q  <= sat16(32'(signed'(pxr[59:40])));
      pz_q  <= sat16(32'(signed'(pzr[59:40])));
      py_q  <= sat16(32'(signed'(pyr[47:20])));
    end
  end

  assign m_axis_tdata = {4'd0, v_dl_q[37], u_dl_q[33], pz_q, py_q, px_q,
                         vn_dl_q[LAST_STAGE-1]};

  // An accepted transaction always occupies the first stage afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  // The folded CORDIC cosine and sine stay within one in magnitude, up to rounding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[47] |-> (cs_dl_q[0].c20 <= 22'sd1048592) && (cs_dl_q[0].c20 >= -22'sd1048592) &&
                  (cs_dl_q[0].s20 <= 22'sd1048592) && (cs_dl_q[0].s20 >= -22'sd1048592))
    else $error("cosine or sine out of range");

  // The ring radius never exceeds one in Q.20.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[61] && !d_zero |-> (quot_r <= 30'd1048576))
    else $error("ring radius out of range");

endmodule

`default_nettype wire
